// File: rtl/pdmv_pkg.sv
`timescale 1ns / 1ps

package pdmv_pkg;

  // Pair store geometry
  localparam int PAIR_SLOTS = 1024;
  localparam int SLOT_W     = $clog2(PAIR_SLOTS);

  // Field and datapath widths
  localparam int COORD_W = 20;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = SQ_W / 2;
  localparam int DSUM_W  = 37;
  localparam int SSUM_W  = 58;
  localparam int CNT_W   = 16;
  localparam int MEAN_W  = 21;
  localparam int VAR_W   = 42;
  localparam int ENTRY_W = DSUM_W + SSUM_W;

  // Stream word widths
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 80;

  // Iterative unit step counts
  localparam int RT_STEPS   = DIST_W;
  localparam int RT_CNT_W   = $clog2(RT_STEPS + 1);
  localparam int DIV_W      = SSUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int DQ_STEPS   = DSUM_W;
  localparam int SQ_STEPS   = SSUM_W;
  localparam int RT_REM_W   = DIST_W + 3;

  // Saturation limits
  localparam logic [DSUM_W-1:0] DSUM_MAX = {DSUM_W{1'b1}};
  localparam logic [SSUM_W-1:0] SSUM_MAX = {SSUM_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
  localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // Request to the square root unit
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } rt_req_t;

  // Request to the divider
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_W-1:0]     dividend;
    logic [CNT_W-1:0]     divisor;
  } div_req_t;

endpackage

// File: rtl/pdmv_isqrt.sv
`timescale 1ns / 1ps

module pdmv_isqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pdmv_pkg::rt_req_t      req_i,
  output logic                   done_o,
  output logic [pdmv_pkg::DIST_W-1:0] root_o
);
  import pdmv_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [RT_CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]     rad_q;
  logic [RT_REM_W-1:0] rem_q;
  logic [DIST_W-1:0]   root_q;
  logic [RT_REM_W-1:0] rem_sh;
  logic [RT_REM_W-1:0] trial;
  logic                fits;

  // Bring down the next two radicand bits and try the next root bit
  assign rem_sh = {rem_q[RT_REM_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  // Control: one root bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= RT_CNT_W'(RT_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == RT_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring digit-by-digit root
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[SQ_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[DIST_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[DIST_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("root done without a running pass");

  property p_no_restart;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> !req_i.start;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("root unit started while busy");

  property p_rem_bound;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> (rem_q[RT_REM_W-1:RT_REM_W-2] == 2'b00);
  endproperty
  a_rem_bound: assert property (p_rem_bound)
    else $error("root remainder overflow");

endmodule

// File: rtl/pdmv_div.sv
`timescale 1ns / 1ps

module pdmv_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pdmv_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [pdmv_pkg::DIV_W-1:0]  quotient_o
);
  import pdmv_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [DIV_W-1:0]     quo_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     dvs_q;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 fits;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  // Control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring division, dividend taken from its top bit down
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("divider done without a running pass");

  property p_no_restart;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> !req_i.start;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("divider started while busy");

  property p_rem_below;
    @(posedge clk_i) disable iff (!rst_ni) busy_q |-> (rem_q < dvs_q);
  endproperty
  a_rem_below: assert property (p_rem_below)
    else $error("divider remainder not below divisor");

endmodule

// File: rtl/pair_distance_mean_variance_unit.sv
`timescale 1ns / 1ps

// Work per item: most of it is in the bit-serial divider (37 steps for the mean, 58 for
//   the mean square) and the 21-step root.
// Throughput: one item at a time; with a shape count of zero the divisions are
//   skipped.
// Reset: clears the shape count, then sweeps the 1024-entry pair store to zero,
//   one entry a cycle, before the first item is accepted.
module pair_distance_mean_variance_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // bits: pair_index[9:0], x_first[29:10], y_first[49:30], z_first[69:50],
  //       x_second[89:70], y_second[109:90], z_second[129:110], zero pad
  input  logic [pdmv_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // bits: new_shape[0]
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // bits: pair_echo[9:0], mean_distance[30:10], distance_variance[72:31], zero pad
  output logic [pdmv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import pdmv_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_RT_GO,
    S_RT_WAIT,
    S_ACC,
    S_DQ_GO,
    S_DQ_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_MSQ,
    S_VAR,
    S_FIN
  } state_e;

  state_e state_q;

  logic [SLOT_W-1:0]  clr_q;
  logic [CNT_W-1:0]   count_q;
  logic [1:0]         k_q;
  logic               m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // Payload registers
  logic [SLOT_W-1:0]  idx_q;
  logic [COORD_W-1:0] xa_q, ya_q, za_q, xb_q, yb_q, zb_q;
  logic [DIFF_W-1:0]  dx_q, dy_q, dz_q;
  logic [SQ_W-1:0]    p_q;
  logic [SQ_W-1:0]    sq_q;
  logic [DIST_W-1:0]  dist_q;
  logic [DSUM_W-1:0]  dsum_q;
  logic [SSUM_W-1:0]  ssum_q;
  logic [MEAN_W-1:0]  mean_q;
  logic [SSUM_W-1:0]  msq_q;
  logic [VAR_W-1:0]   var_q;

  // Pair store
  logic [ENTRY_W-1:0] mem [PAIR_SLOTS];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic               in_acc;
  logic [DIFF_W-1:0]  ax, ay, az;
  logic [DIFF_W-1:0]  mul_a;
  logic [DSUM_W:0]    dsum_add;
  logic [SSUM_W:0]    ssum_add;
  logic [DSUM_W-1:0]  dsum_new;
  logic [SSUM_W-1:0]  ssum_new;
  logic [DSUM_W-1:0]  dq;
  logic [MEAN_W-1:0]  mean_sat;
  logic [SSUM_W-1:0]  var_diff;
  logic [VAR_W-1:0]   var_val;

  rt_req_t            rt_req;
  logic               rt_done;
  logic [DIST_W-1:0]  rt_root;
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;

  // Absolute coordinate difference
  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign ax = abs_diff(xa_q, xb_q);
  assign ay = abs_diff(ya_q, yb_q);
  assign az = abs_diff(za_q, zb_q);

  // Shared squarer operand: the three differences, then the mean
  always_comb begin
    if (state_q == S_MSQ) begin
      mul_a = mean_q;
    end else begin
      unique case (k_q)
        2'd0:    mul_a = dx_q;
        2'd1:    mul_a = dy_q;
        default: mul_a = dz_q;
      endcase
    end
  end

  // Saturating sum update
  assign dsum_add = {1'b0, rd_q[DSUM_W-1:0]} + (DSUM_W + 1)'(dist_q);
  assign ssum_add = {1'b0, rd_q[ENTRY_W-1:DSUM_W]} + (SSUM_W + 1)'(sq_q);
  assign dsum_new = dsum_add[DSUM_W] ? DSUM_MAX : dsum_add[DSUM_W-1:0];
  assign ssum_new = ssum_add[SSUM_W] ? SSUM_MAX : ssum_add[SSUM_W-1:0];

  // Mean saturation and clamped variance
  assign dq       = div_quo[DSUM_W-1:0];
  assign mean_sat = (|dq[DSUM_W-1:MEAN_W]) ? MEAN_MAX : dq[MEAN_W-1:0];
  assign var_diff = msq_q - SSUM_W'(p_q);
  assign var_val  = (msq_q <= SSUM_W'(p_q)) ? '0 :
                    (|var_diff[SSUM_W-1:VAR_W]) ? VAR_MAX : var_diff[VAR_W-1:0];

  // Unit requests
  assign rt_req.start    = (state_q == S_RT_GO);
  assign rt_req.radicand = sq_q;

  always_comb begin
    div_req.start   = (state_q == S_DQ_GO) || (state_q == S_SQ_GO);
    div_req.divisor = count_q;
    if (state_q == S_SQ_GO) begin
      div_req.steps    = DIV_CNT_W'(SQ_STEPS);
      div_req.dividend = ssum_q;
    end else begin
      div_req.steps    = DIV_CNT_W'(DQ_STEPS);
      div_req.dividend = {dsum_q, {(DIV_W - DSUM_W){1'b0}}};
    end
  end

  pdmv_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rt_req),
    .done_o (rt_done),
    .root_o (rt_root)
  );

  pdmv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Store port: clearing sweep or sum write-back
  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_ACC);
  assign mem_addr  = (state_q == S_CLEAR) ? clr_q : idx_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : {ssum_new, dsum_new};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (state_q == S_DIFF) begin
      rd_q <= mem[idx_q];
    end
  end

  // Shared squarer, registered
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_a;
  end

  // Sequencer, shape count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      count_q   <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // drop the output item once taken, unless a new one loads this cycle
      if (m_valid_q && m_axis_tready_i && (state_q != S_FIN)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SLOT_W'(PAIR_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser_i && (count_q != CNT_MAX)) begin
              count_q <= count_q + 1'b1;
            end
            state_q <= S_DIFF;
          end
        end
        S_DIFF: begin
          k_q     <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          k_q <= k_q + 1'b1;
          if (k_q == 2'd3) begin
            state_q <= S_RT_GO;
          end
        end
        S_RT_GO:   state_q <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (rt_done) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          state_q <= (count_q == '0) ? S_FIN : S_DQ_GO;
        end
        S_DQ_GO:   state_q <= S_DQ_WAIT;
        S_DQ_WAIT: begin
          if (div_done) begin
            state_q <= S_SQ_GO;
          end
        end
        S_SQ_GO:   state_q <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (div_done) begin
            state_q <= S_MSQ;
          end
        end
        S_MSQ:     state_q <= S_VAR;
        S_VAR:     state_q <= S_FIN;
        S_FIN: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers along the sequence
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q <= s_axis_tdata_i[SLOT_W-1:0];
      xa_q  <= s_axis_tdata_i[10 +: COORD_W];
      ya_q  <= s_axis_tdata_i[30 +: COORD_W];
      za_q  <= s_axis_tdata_i[50 +: COORD_W];
      xb_q  <= s_axis_tdata_i[70 +: COORD_W];
      yb_q  <= s_axis_tdata_i[90 +: COORD_W];
      zb_q  <= s_axis_tdata_i[110 +: COORD_W];
    end
    if (state_q == S_DIFF) begin
      dx_q <= ax;
      dy_q <= ay;
      dz_q <= az;
      sq_q <= '0;
    end
    if (state_q == S_MUL && k_q != 2'd0) begin
      sq_q <= sq_q + p_q;
    end
    if (rt_done) begin
      dist_q <= rt_root;
    end
    if (state_q == S_ACC) begin
      dsum_q <= dsum_new;
      ssum_q <= ssum_new;
      mean_q <= '0;
      var_q  <= '0;
    end
    if (state_q == S_DQ_WAIT && div_done) begin
      mean_q <= mean_sat;
    end
    if (state_q == S_SQ_WAIT && div_done) begin
      msq_q <= div_quo;
    end
    if (state_q == S_VAR) begin
      var_q <= var_val;
    end
    if (state_q == S_FIN && (!m_valid_q || m_axis_tready_i)) begin
      m_data_q <= {{(OUT_TDATA_W - VAR_W - MEAN_W - SLOT_W){1'b0}}, var_q, mean_q, idx_q};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  property p_no_take_in_clear;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_CLEAR) |-> !s_axis_tready_o;
  endproperty
  a_no_take_in_clear: assert property (p_no_take_in_clear)
    else $error("item accepted during store clearing");

  property p_count_monotonic;
    @(posedge clk_i) disable iff (!rst_ni) count_q >= $past(count_q);
  endproperty
  a_count_monotonic: assert property (p_count_monotonic)
    else $error("shape count went down");

  property p_fin_loads;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_FIN && !m_valid_q) |=> m_valid_q;
  endproperty
  a_fin_loads: assert property (p_fin_loads)
    else $error("finished result not loaded into free output register");

  property p_div_done_waiting;
    @(posedge clk_i) disable iff (!rst_ni)
      div_done |-> (state_q == S_DQ_WAIT || state_q == S_SQ_WAIT);
  endproperty
  a_div_done_waiting: assert property (p_div_done_waiting)
    else $error("divider finished outside a wait state");

  property p_rt_done_waiting;
    @(posedge clk_i) disable iff (!rst_ni) rt_done |-> (state_q == S_RT_WAIT);
  endproperty
  a_rt_done_waiting: assert property (p_rt_done_waiting)
    else $error("root finished outside its wait state");

endmodule
